FILE: rtl/core/partition_window_crc32_core_macros.svh
// Assertion macros shared by the partition window CRC-32 core.
`ifndef PARTITION_WINDOW_CRC32_CORE_MACROS_SVH
`define PARTITION_WINDOW_CRC32_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PWC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PWC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/pwc_pkg.sv
// Types, constants and the CRC-32 byte update for the partition window core.
`timescale 1ns / 1ps

package pwc_pkg;

  typedef logic [31:0] addr_t;
  typedef logic [23:0] len_t;
  typedef logic [1:0]  part_t;
  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  cfg_idx_t;

  typedef addr_t [3:0] base_arr_t;
  typedef len_t  [3:0] size_arr_t;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 64;

  localparam addr_t CRC_POLY   = 32'hEDB8_8320;
  localparam addr_t CRC_INIT   = 32'hFFFF_FFFF;
  localparam addr_t BASE_RESET = 32'h0800_0000;

  // Request kinds carried on the input tuser
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_DATA  = 1'b1;

  // Configuration register indexes
  localparam cfg_idx_t CFG_BOOT_BASE     = 3'd0;
  localparam cfg_idx_t CFG_APP_BASE      = 3'd1;
  localparam cfg_idx_t CFG_BACKUP_BASE   = 3'd2;
  localparam cfg_idx_t CFG_SETTINGS_BASE = 3'd3;
  localparam cfg_idx_t CFG_BOOT_SIZE     = 3'd4;
  localparam cfg_idx_t CFG_APP_SIZE      = 3'd5;
  localparam cfg_idx_t CFG_BACKUP_SIZE   = 3'd6;
  localparam cfg_idx_t CFG_SETTINGS_SIZE = 3'd7;

  // Partition codes
  localparam part_t PART_BOOT     = 2'd0;
  localparam part_t PART_APP      = 2'd1;
  localparam part_t PART_BACKUP   = 2'd2;
  localparam part_t PART_SETTINGS = 2'd3;

  typedef struct packed {
    logic  action;
    part_t partition;
    len_t  offset;
    len_t  length;
    byte_t data_byte;
  } in_item_t;

  typedef struct packed {
    logic  ok;
    addr_t phys_addr;
    addr_t crc_value;
    logic  done_res;
  } res_t;

  // Reflected CRC-32 over one byte, LSB first
  function automatic addr_t crc32_byte(input addr_t c, input byte_t b);
    addr_t r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/partition_window_crc32_core.sv
// Top level: stream ports, configuration registers, input register, engine and result register.
`timescale 1ns / 1ps

// Partition window check with CRC-32. A start request (tuser 0) names a
// partition, offset and length; the block answers ok and base + offset if the
// window fits, else not ok, and after a good window of nonzero length takes
// exactly that many data requests (tuser 1), answering once with the inverted
// reflected CRC-32 and tlast set. A zero-length window answers done at once;
// data requests while idle are dropped. One request is taken every cycle
// while the result register has room; each passes an input register, window
// compare and byte-wide CRC logic, and a result register. Input ready falls
// only while the result register holds an untaken result. The user must write
// configuration only while no request is in flight; the block does not enforce it.
module partition_window_crc32_core
  import pwc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port
  input  logic                   cfg_we,
  input  cfg_idx_t               cfg_index,
  input  addr_t                  cfg_data,
  // Request stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: partition[1:0], offset[25:2], length[49:26], data_byte[57:50], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: action
  input  logic [0:0]             s_axis_tuser,
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: phys_addr[31:0], crc_value[63:32]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: ok
  output logic [0:0]             m_axis_tuser,
  // tlast: done_res
  output logic                   m_axis_tlast
);

  base_arr_t base;
  size_arr_t size;
  logic      in_valid;
  in_item_t  in_item;
  logic      eng_fire;
  logic      has_result;
  res_t      result;
  res_t      out_res;

  pwc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .base      (base),
    .size      (size)
  );

  // Engine advances when the result register has room
  assign eng_fire      = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || eng_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.action    <= s_axis_tuser[0];
      in_item.partition <= s_axis_tdata[1:0];
      in_item.offset    <= s_axis_tdata[25:2];
      in_item.length    <= s_axis_tdata[49:26];
      in_item.data_byte <= s_axis_tdata[57:50];
    end
  end

  pwc_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .fire       (eng_fire),
    .item       (in_item),
    .base       (base),
    .size       (size),
    .has_result (has_result),
    .result     (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (eng_fire && has_result) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_fire && has_result) begin
      out_res <= result;
    end
  end

  assign m_axis_tdata = {out_res.crc_value, out_res.phys_addr};
  assign m_axis_tuser = out_res.ok;
  assign m_axis_tlast = out_res.done_res;

endmodule

FILE: rtl/core/pwc_cfg_regs.sv
// Base and size registers of the four partitions.
`timescale 1ns / 1ps

module pwc_cfg_regs
  import pwc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_index,
  input  addr_t     cfg_data,
  output base_arr_t base,
  output size_arr_t size
);

  // Register writes; size registers keep the low 24 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= {4{BASE_RESET}};
      size <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOOT_BASE:     base[PART_BOOT]     <= cfg_data;
        CFG_APP_BASE:      base[PART_APP]      <= cfg_data;
        CFG_BACKUP_BASE:   base[PART_BACKUP]   <= cfg_data;
        CFG_SETTINGS_BASE: base[PART_SETTINGS] <= cfg_data;
        CFG_BOOT_SIZE:     size[PART_BOOT]     <= cfg_data[23:0];
        CFG_APP_SIZE:      size[PART_APP]      <= cfg_data[23:0];
        CFG_BACKUP_SIZE:   size[PART_BACKUP]   <= cfg_data[23:0];
        CFG_SETTINGS_SIZE: size[PART_SETTINGS] <= cfg_data[23:0];
      endcase
    end
  end

endmodule

FILE: rtl/core/pwc_engine.sv
// Window check and running CRC-32 state; builds at most one result per request.
`timescale 1ns / 1ps

module pwc_engine
  import pwc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_item_t  item,
  input  base_arr_t base,
  input  size_arr_t size,
  output logic      has_result,
  output res_t      result
);

`include "partition_window_crc32_core_macros.svh"

  addr_t crc_reg, crc_reg_next;
  len_t  bytes_left, bytes_left_next;
  logic  busy, busy_next;

  logic [24:0] window_end;
  logic        fits;
  addr_t       crc_upd;
  len_t        left_dec;

  // Window bounds at full width, and the byte update
  assign window_end = {1'b0, item.offset} + {1'b0, item.length};
  assign fits       = window_end <= {1'b0, size[item.partition]};
  assign crc_upd    = crc32_byte(crc_reg, item.data_byte);
  assign left_dec   = bytes_left - 24'd1;

  // Next state and result
  always_comb begin
    crc_reg_next    = crc_reg;
    bytes_left_next = bytes_left;
    busy_next       = busy;
    has_result      = 1'b0;
    result          = '0;
    if (item.action == ACT_START) begin
      crc_reg_next    = CRC_INIT;
      bytes_left_next = '0;
      busy_next       = 1'b0;
      has_result      = 1'b1;
      if (fits) begin
        result.ok        = 1'b1;
        result.phys_addr = base[item.partition] + {8'h0, item.offset};
        if (item.length == '0) begin
          result.done_res = 1'b1;
        end else begin
          bytes_left_next = item.length;
          busy_next       = 1'b1;
        end
      end
    end else if (busy) begin
      bytes_left_next = left_dec;
      if (left_dec == '0) begin
        busy_next        = 1'b0;
        crc_reg_next     = CRC_INIT;
        has_result       = 1'b1;
        result.ok        = 1'b1;
        result.crc_value = crc_upd ^ CRC_INIT;
        result.done_res  = 1'b1;
      end else begin
        crc_reg_next = crc_upd;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg    <= CRC_INIT;
      bytes_left <= '0;
      busy       <= 1'b0;
    end else if (fire) begin
      crc_reg    <= crc_reg_next;
      bytes_left <= bytes_left_next;
      busy       <= busy_next;
    end
  end

  `PWC_ASSERT_IMP(a_busy_has_bytes, clk, rst, busy, bytes_left != '0, "busy with no bytes left")
  `PWC_ASSERT_IMP(a_idle_crc_init, clk, rst, !busy, crc_reg == CRC_INIT, "idle with stale CRC")
  `PWC_ASSERT_IMP(a_done_is_ok, clk, rst, has_result && result.done_res, result.ok,
                  "completed checksum without ok")
  `PWC_ASSERT_NXT(a_start_resets_crc, clk, rst, fire && item.action == ACT_START,
                  crc_reg == CRC_INIT, "start did not reinitialize CRC")

endmodule

FILE: sim/pwc_window_checker.sv
// Checker for the partition window CRC-32 core: watches both streams, predicts and compares.
`timescale 1ns / 1ps

module pwc_window_checker
  import pwc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  cfg_idx_t               cfg_index,
  input  addr_t                  cfg_data,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // tdata: partition[1:0], offset[25:2], length[49:26], data_byte[57:50], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: action
  input  logic [0:0]             s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: phys_addr[31:0], crc_value[63:32]
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: ok
  input  logic [0:0]             m_axis_tuser,
  input  logic                   m_axis_tlast,
  input  logic                   closing,
  output logic                   closed,
  output int                     n_pending,
  output int                     n_fail
);

  // Shadow of the partition registers and of the running window
  addr_t part_base [4];
  len_t  part_size [4];
  addr_t crc_run;
  len_t  bytes_to_go;
  logic  in_window;
  res_t  expected_results [$];

  task automatic log_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    n_fail++;
  endtask

  task automatic cmp_field(input string name, input addr_t got, input addr_t want);
    if (got !== want)
      log_mismatch($sformatf("%s got %h, want %h", name, got, want));
  endtask

  function automatic res_t result_of(input logic ok, input addr_t addr, input addr_t crc,
                                     input logic done);
    res_t r;
    r.ok        = ok;
    r.phys_addr = addr;
    r.crc_value = crc;
    r.done_res  = done;
    return r;
  endfunction

  // Bit-serial reflected CRC-32: feed the data bit into the feedback term
  function automatic addr_t crc_advance(input addr_t c, input byte_t b);
    addr_t r;
    logic  fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t        got;
    res_t        want;
    part_t       part;
    len_t        off;
    len_t        len;
    byte_t       data;
    logic [24:0] reach;
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        part_base[i] = BASE_RESET;
        part_size[i] = '0;
      end
      crc_run     = CRC_INIT;
      bytes_to_go = '0;
      in_window   = 1'b0;
      expected_results.delete();
      n_fail      = 0;
      n_pending  <= 0;
      closed     <= 1'b0;
    end else begin
      // Register writes
      if (cfg_we) begin
        if (cfg_index < CFG_BOOT_SIZE) part_base[cfg_index[1:0]] = cfg_data;
        else part_size[cfg_index[1:0]] = cfg_data[23:0];
      end

      // Results leaving the block
      if (m_axis_tvalid && m_axis_tready) begin
        got.ok        = m_axis_tuser[0];
        got.phys_addr = m_axis_tdata[31:0];
        got.crc_value = m_axis_tdata[63:32];
        got.done_res  = m_axis_tlast;
        if (expected_results.size() == 0) begin
          log_mismatch($sformatf("unexpected result ok=%b addr=%h crc=%h done=%b",
                                 got.ok, got.phys_addr, got.crc_value, got.done_res));
        end else begin
          want = expected_results.pop_front();
          cmp_field("ok", {31'h0, got.ok}, {31'h0, want.ok});
          cmp_field("phys_addr", got.phys_addr, want.phys_addr);
          cmp_field("crc_value", got.crc_value, want.crc_value);
          cmp_field("done_res", {31'h0, got.done_res}, {31'h0, want.done_res});
        end
      end

      // Requests entering the block
      if (s_axis_tvalid && s_axis_tready) begin
        part = s_axis_tdata[1:0];
        off  = s_axis_tdata[25:2];
        len  = s_axis_tdata[49:26];
        data = s_axis_tdata[57:50];
        if (s_axis_tuser[0] == ACT_START) begin
          // a start always drops whatever window was running
          in_window   = 1'b0;
          bytes_to_go = '0;
          crc_run     = CRC_INIT;
          reach       = {1'b0, off} + {1'b0, len};
          if (reach > {1'b0, part_size[part]}) begin
            expected_results.push_back(result_of(1'b0, '0, '0, 1'b0));
          end else if (len == '0) begin
            expected_results.push_back(result_of(1'b1, part_base[part] + {8'h0, off}, '0, 1'b1));
          end else begin
            bytes_to_go = len;
            in_window   = 1'b1;
            expected_results.push_back(result_of(1'b1, part_base[part] + {8'h0, off}, '0, 1'b0));
          end
        end else if (in_window) begin
          crc_run     = crc_advance(crc_run, data);
          bytes_to_go = bytes_to_go - 1'b1;
          if (bytes_to_go == '0) begin
            in_window = 1'b0;
            expected_results.push_back(result_of(1'b1, '0, crc_run ^ CRC_INIT, 1'b1));
            crc_run   = CRC_INIT;
          end
        end
      end

      // End of run: anything still queued never came out
      if (closing && !closed) begin
        if (expected_results.size() != 0)
          log_mismatch($sformatf("%0d expected results never arrived",
                                 expected_results.size()));
        closed <= 1'b1;
      end
      n_pending <= expected_results.size();
    end
  end

endmodule

FILE: sim/tb.sv
// Testbench top for the partition window CRC-32 core: clock, reset, traffic and verdict.
`timescale 1ns / 1ps

module tb;
  import pwc_pkg::*;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   cfg_we        = 1'b0;
  cfg_idx_t               cfg_index     = CFG_BOOT_BASE;
  addr_t                  cfg_data      = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]             s_axis_tuser  = ACT_START;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;
  logic                   m_axis_tlast;

  logic closing = 1'b0;
  logic closed;
  int   n_pending;
  int   n_fail;

  // Traffic shaping shared by the sender and the receiver
  logic calm     = 1'b0;
  int   hold_ask = 0;
  int   counted  = 0;
  len_t size_now [4];

  always #5 clk = ~clk;

  partition_window_crc32_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  pwc_window_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .closing       (closing),
    .closed        (closed),
    .n_pending     (n_pending),
    .n_fail        (n_fail)
  );

  // One request, with random gaps ahead of it; returns at the accepting edge
  task automatic push_req(input logic act, input part_t part, input len_t off, input len_t len,
                          input byte_t data);
    while (!calm && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {6'h0, data, len, off, part};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic push_byte(input byte_t data);
    push_req(ACT_DATA, part_t'($urandom_range(3)), len_t'($urandom()), len_t'($urandom()), data);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input addr_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx >= CFG_BOOT_SIZE) size_now[idx[1:0]] = val[23:0];
    @(posedge clk);
  endtask

  // Stop sending, wait for every result, then let the pipeline drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic addr_t pick_base();
    case ($urandom_range(3))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic len_t size_for(input int phase, input int slot);
    case (phase)
      0:       return len_t'($urandom_range(24'hFF_FFFF));
      1:       return (slot < 2) ? 24'hFF_FFFF : (slot == 3) ? 24'h0 : len_t'($urandom_range(64));
      2:       return len_t'($urandom_range(300));
      default: return 24'hFF_FFFF;
    endcase
  endfunction

  // One window: mostly well formed, some cut short, some overlong, some out of bounds, some noise
  task automatic run_window();
    part_t part;
    len_t  sz;
    len_t  len;
    len_t  off;
    int    kind;
    int    nbytes;
    int    len_i;
    part = part_t'($urandom_range(3));
    sz   = size_now[part];
    kind = $urandom_range(99);
    if (kind >= 90) begin
      repeat ($urandom_range(3, 1))
        push_req(logic'($urandom_range(1)), part_t'($urandom_range(3)), len_t'($urandom()),
                 len_t'($urandom()), byte_t'($urandom()));
    end else begin
      if ($urandom_range(9) == 0) len = '0;
      else if ($urandom_range(9) == 0) len = len_t'($urandom_range(40, 13));
      else len = len_t'($urandom_range(12, 1));
      if (len > sz) len = sz;
      off    = len_t'($urandom_range(sz - len));
      len_i  = int'({8'h0, len});
      nbytes = len_i;
      if (kind >= 80) begin
        // just past the end, or anywhere at all
        if ($urandom_range(1) && sz != 24'hFF_FFFF) begin
          off = sz - len + 1'b1;
        end else begin
          off = len_t'($urandom());
          len = len_t'($urandom());
        end
        nbytes = int'($urandom_range(3));
      end else if (kind >= 70) begin
        nbytes = (len_i > 1) ? int'($urandom_range(len_i - 1)) : 0;
      end else if (kind >= 64) begin
        nbytes = len_i + int'($urandom_range(2, 1));
      end
      push_req(ACT_START, part, off, len, byte_t'($urandom()));
      counted++;
      repeat (nbytes) push_byte(byte_t'($urandom()));
      if (kind < 80) counted += (nbytes < len_i) ? nbytes : len_i;
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin : sink
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_ask != holds_done) begin
        holds_done = hold_ask;
        m_axis_tready <= 1'b0;
        repeat (250) @(posedge clk);
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 31);
    end
  end

  initial begin : source
    logic paused;
    paused = 1'b0;
    for (int i = 0; i < 4; i++) size_now[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: every size is zero
    push_req(ACT_START, PART_BOOT, 24'h0, 24'h0, 8'h00);
    push_req(ACT_START, PART_APP, 24'h0, 24'h1, 8'hFF);
    push_req(ACT_DATA, PART_SETTINGS, 24'hFF_FFFF, 24'hFF_FFFF, 8'hA5);
    settle();

    // Extreme settings for the directed windows
    cfg_write(CFG_BOOT_BASE, 32'hFFFF_FFFF);
    cfg_write(CFG_APP_BASE, 32'h0);
    cfg_write(CFG_BACKUP_BASE, 32'h2000_0000);
    cfg_write(CFG_SETTINGS_BASE, 32'h0800_4000);
    cfg_write(CFG_BOOT_SIZE, 32'h00FF_FFFF);
    cfg_write(CFG_APP_SIZE, 32'h4);
    cfg_write(CFG_BACKUP_SIZE, 32'h0);
    cfg_write(CFG_SETTINGS_SIZE, 32'h8);
    cfg_we <= 1'b0;

    // base + offset wraps; the window sum exceeds 24 bits
    push_req(ACT_START, PART_BOOT, 24'hFF_FFFF, 24'h0, 8'h00);
    push_req(ACT_START, PART_BOOT, 24'hFF_FFFF, 24'hFF_FFFF, 8'h00);
    push_req(ACT_START, PART_BOOT, 24'h1, 24'hFF_FFFF, 8'h00);
    // long window abandoned by a new start
    push_req(ACT_START, PART_BOOT, 24'h0, 24'hFF_FFFF, 8'h00);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h5A);
    push_req(ACT_START, PART_APP, 24'h0, 24'h4, 8'h00);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h31);
    push_byte(8'h80);
    // zero length at the very end, one past the end, empty partition
    push_req(ACT_START, PART_APP, 24'h4, 24'h0, 8'h00);
    push_req(ACT_START, PART_APP, 24'h3, 24'h2, 8'h00);
    push_req(ACT_START, PART_BACKUP, 24'h0, 24'h0, 8'h00);
    push_req(ACT_START, PART_BACKUP, 24'h0, 24'h1, 8'h00);
    push_req(ACT_START, PART_SETTINGS, 24'h7, 24'h1, 8'h00);
    push_byte(8'h7E);
    // byte with no window open
    push_byte(8'hFF);
    settle();

    // Random phases, each under its own settings
    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < 4; i++) cfg_write(cfg_idx_t'(CFG_BOOT_BASE + i), pick_base());
      for (int i = 0; i < 4; i++) cfg_write(cfg_idx_t'(CFG_BOOT_SIZE + i), {8'h0, size_for(ph, i)});
      cfg_we <= 1'b0;
      calm    = (ph == 2);
      counted = 0;
      while (counted < 350) begin
        run_window();
        if (ph == 1 && hold_ask == 0 && counted >= 150) hold_ask++;
        if (ph == 3 && !paused && counted >= 150) begin
          paused = 1'b1;
          settle();
        end
      end
      settle();
    end

    closing <= 1'b1;
    @(posedge clk);
    while (!closed) @(posedge clk);
    if (n_fail == 0) begin
      $display("partition_window_crc32_core verification clean");
    end else begin
      $display("partition_window_crc32_core verification failed");
    end
    $finish;
  end

  // Watchdog on the whole run
  initial begin : watchdog
    #3_000_000;
    $display("partition_window_crc32_core verification failed");
    $finish;
  end

endmodule
